@@ rtl/core/idpi_pkg.sv @@
// Package for the inverse-distance parameter interpolator.
// Word types, request and status codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package idpi_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int MAX_PARAMS_DEF = 64;

  localparam int D2W    = 34;   // squared distance, Q2.32
  localparam int FORCEW = 24;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_WRITE  = 2'd2;
  localparam logic [1:0] REQ_QUERY  = 2'd3;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_RANGE = 2'd3;

  localparam logic [1:0] CFG_PARAMS = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;

  localparam logic [6:0]  PARAMS_RST = 7'd64;
  localparam logic [31:0] THRESH_RST = 32'd42950;
  localparam logic [15:0] RADIUS_RST = 16'd655;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  point_index;
    logic [5:0]  param_index;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [15:0] param_value;
  } req_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         out_param_index;
    logic [15:0]        out_value;
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic signed [23:0] force_z;
    logic               last;
  } rsp_word_t;

endpackage

`default_nettype wire

@@ rtl/core/inverse_distance_param_interpolator_unit.sv @@
// Inverse-distance parameter interpolator, top level: sequencer, tables, multiplier.
// Depends on idpi_pkg and idpi_div.
//
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------
//  request | req_valid / req_stall | req (req_word_t)
//  result  | rsp_valid / rsp_stall | rsp (rsp_word_t), last marks end
//  config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Clear, append and parameter write each return one status word. On the weighted
// path a query with n points and m parameters runs the distance, force (unless a point
// is within the radius), weight and output passes; all divides share the one divider.
// The nearest-point path skips the weights and emits m words, one table read per word.
// Reset (rst, synchronous) empties the table and loads the register defaults.
// A stalled result word holds the sequencer; no request is taken until done.
`default_nettype none

module inverse_distance_param_interpolator_unit
  import idpi_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_word_t   req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_word_t        rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int PAW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW     = $clog2(MAX_POINTS + 1);
  localparam int JW     = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int MW     = $clog2(MAX_PARAMS + 1);
  localparam int VDEPTH = MAX_POINTS * MAX_PARAMS;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int SUMW   = 53 + CW;
  localparam int ACCW   = 48 + CW;
  localparam int NUMW   = (ACCW > 53) ? ACCW : 53;
  localparam int FACCW  = 34 + CW;

  localparam logic signed [FACCW-1:0] FMAX = FACCW'(8388607);
  localparam logic signed [FACCW-1:0] FMIN = FACCW'(-8388608);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_EXEC   = 5'd1;
  localparam logic [4:0] ST_EMIT1  = 5'd2;
  localparam logic [4:0] ST_Q_RR   = 5'd3;
  localparam logic [4:0] ST_D_RD   = 5'd4;
  localparam logic [4:0] ST_D_SQ   = 5'd5;
  localparam logic [4:0] ST_D_ACC  = 5'd6;
  localparam logic [4:0] ST_D_END  = 5'd7;
  localparam logic [4:0] ST_F_RD   = 5'd8;
  localparam logic [4:0] ST_F_MUL  = 5'd9;
  localparam logic [4:0] ST_F_DIV  = 5'd10;
  localparam logic [4:0] ST_F_WAIT = 5'd11;
  localparam logic [4:0] ST_F_SAT  = 5'd12;
  localparam logic [4:0] ST_SEL    = 5'd13;
  localparam logic [4:0] ST_N_RD   = 5'd14;
  localparam logic [4:0] ST_N_EMIT = 5'd15;
  localparam logic [4:0] ST_W_DIV  = 5'd16;
  localparam logic [4:0] ST_W_WAIT = 5'd17;
  localparam logic [4:0] ST_SHIFT  = 5'd18;
  localparam logic [4:0] ST_DEN    = 5'd19;
  localparam logic [4:0] ST_O_RD   = 5'd20;
  localparam logic [4:0] ST_O_MUL  = 5'd21;
  localparam logic [4:0] ST_O_ACC  = 5'd22;
  localparam logic [4:0] ST_O_DIV  = 5'd23;
  localparam logic [4:0] ST_O_WAIT = 5'd24;
  localparam logic [4:0] ST_O_EMIT = 5'd25;

  function automatic logic signed [23:0] sat24(input logic signed [FACCW-1:0] v);
    logic signed [23:0] r;
    if (v > FMAX)      r = 24'sh7FFFFF;
    else if (v < FMIN) r = 24'sh800000;
    else               r = 24'(v);
    return r;
  endfunction

  logic [4:0]      state;
  req_word_t       rq;
  logic [6:0]      cfg_params;
  logic [31:0]     cfg_thr;
  logic [15:0]     cfg_rad;
  logic [CW-1:0]   count;
  logic [1:0]      status;

  logic [47:0]     pos_mem [MAX_POINTS];
  logic [47:0]     pos_rd;
  logic [15:0]     val_mem [VDEPTH];
  logic [15:0]     val_rd;
  logic            pos_we;
  logic            val_we;
  logic [VAW-1:0]  wr_addr;
  logic [VAW-1:0]  rd_addr;
  logic [PAW-1:0]  rd_pt;

  logic [D2W-1:0]  d2 [MAX_POINTS];
  logic [52:0]     wt [MAX_POINTS];
  logic [PAW-1:0]  pt;
  logic [PAW-1:0]  best;
  logic [JW-1:0]   j;
  logic [MW-1:0]   m;
  logic [1:0]      ax;
  logic [D2W-1:0]  d2acc;
  logic [D2W-1:0]  best_d2;
  logic [31:0]     rr;
  logic            in_radius;
  logic signed [FACCW-1:0] facc [3];
  logic signed [23:0] fx, fy, fz;
  logic [SUMW-1:0] sum;
  logic [5:0]      sh;
  logic [31:0]     den;
  logic [ACCW-1:0] acc;
  logic [15:0]     res;

  logic [15:0]     pa, qa, mag;
  logic            neg;
  logic [15:0]     mul_a;
  logic [31:0]     mul_b;
  logic [47:0]     prod;
  logic [D2W-1:0]  d2_new;
  logic [52:0]     wsh;
  logic signed [FACCW-1:0] term;

  logic            div_start;
  logic [NUMW-1:0] div_num;
  logic [D2W-1:0]  div_den;
  logic            div_done;
  logic [NUMW-1:0] div_quo;

  logic            pt_last;
  logic            j_last;
  logic            near;
  logic            out_free;
  logic            emit_go;
  rsp_word_t       emit_w;

  assign req_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign pt_last  = (CW'(pt) == count - CW'(1));
  assign j_last   = (MW'(j) == m - MW'(1));
  assign near     = (best_d2 < {2'b00, cfg_thr}) || (best_d2 == '0);
  assign out_free = !rsp_valid || !rsp_stall;
  assign emit_go  = out_free &&
                    (state == ST_EMIT1 || state == ST_N_EMIT || state == ST_O_EMIT);

  // axis select and |point - query|
  always_comb begin
    unique case (ax)
      2'd0:    begin pa = pos_rd[15:0];  qa = rq.pos_x; end
      2'd1:    begin pa = pos_rd[31:16]; qa = rq.pos_y; end
      default: begin pa = pos_rd[47:32]; qa = rq.pos_z; end
    endcase
    neg = (pa < qa);
    mag = neg ? (qa - pa) : (pa - qa);
  end

  // shared multiplier operands
  always_comb begin
    unique case (state)
      ST_EXEC:  begin mul_a = cfg_rad; mul_b = {16'd0, cfg_rad}; end
      ST_D_SQ:  begin mul_a = mag;     mul_b = {16'd0, mag};     end
      ST_F_MUL: begin mul_a = mag;     mul_b = {16'd0, cfg_rad}; end
      ST_O_MUL: begin mul_a = val_rd;  mul_b = wt[pt][31:0];     end
      default:  begin mul_a = '0;      mul_b = '0;               end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    div_start = (state == ST_F_DIV) || (state == ST_W_DIV) || (state == ST_O_DIV);
    unique case (state)
      ST_F_DIV: begin div_num = NUMW'({prod[31:0], 16'd0}); div_den = d2[pt]; end
      ST_W_DIV: begin div_num = NUMW'({1'b1, 52'd0});       div_den = d2[pt]; end
      default:  begin div_num = NUMW'(acc);                 div_den = D2W'(den); end
    endcase
  end

  idpi_div #(
    .NUMW (NUMW),
    .DENW (D2W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign d2_new = d2acc + D2W'(prod[31:0]);
  assign wsh    = wt[pt] >> sh;
  assign term   = $signed(FACCW'(div_quo[32:0]));

  // tables
  assign pos_we  = (state == ST_EXEC) && (rq.req_type == REQ_APPEND) &&
                   (int'(count) < MAX_POINTS);
  assign val_we  = (state == ST_EXEC) && (rq.req_type == REQ_WRITE) &&
                   (int'(rq.point_index) < int'(count)) &&
                   (int'(rq.param_index) < MAX_PARAMS);
  assign wr_addr = VAW'(int'(rq.point_index) * MAX_PARAMS + int'(rq.param_index));
  assign rd_pt   = (state == ST_N_RD || state == ST_N_EMIT) ? best : pt;
  assign rd_addr = VAW'(int'(rd_pt) * MAX_PARAMS + int'(j));

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[count[PAW-1:0]] <= {rq.pos_z, rq.pos_y, rq.pos_x};
    end
    pos_rd <= pos_mem[pt];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= rq.param_value;
    end
    val_rd <= val_mem[rd_addr];
  end

  // result word
  always_comb begin
    emit_w.status          = (state == ST_EMIT1) ? status : STS_OK;
    emit_w.out_param_index = (state == ST_EMIT1) ? 6'd0 : 6'(j);
    emit_w.out_value       = (state == ST_N_EMIT) ? val_rd :
                             (state == ST_O_EMIT) ? res : 16'd0;
    emit_w.force_x         = (state == ST_EMIT1) ? 24'sd0 : fx;
    emit_w.force_y         = (state == ST_EMIT1) ? 24'sd0 : fy;
    emit_w.force_z         = (state == ST_EMIT1) ? 24'sd0 : fz;
    emit_w.last            = (state == ST_EMIT1) || j_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_go) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (emit_go) begin
      rsp <= emit_w;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      cfg_params <= PARAMS_RST;
      cfg_thr    <= THRESH_RST;
      cfg_rad    <= RADIUS_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PARAMS: cfg_params <= cfg_data[6:0];
          CFG_THRESH: cfg_thr    <= cfg_data;
          CFG_RADIUS: cfg_rad    <= cfg_data[15:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            rq    <= req;
            state <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          unique case (rq.req_type)
            REQ_CLEAR: begin
              count  <= '0;
              status <= STS_OK;
              state  <= ST_EMIT1;
            end
            REQ_APPEND: begin
              if (int'(count) >= MAX_POINTS) begin
                status <= STS_FULL;
              end else begin
                count  <= count + CW'(1);
                status <= STS_OK;
              end
              state <= ST_EMIT1;
            end
            REQ_WRITE: begin
              status <= val_we ? STS_OK : STS_RANGE;
              state  <= ST_EMIT1;
            end
            default: begin
              facc[0]   <= '0;
              facc[1]   <= '0;
              facc[2]   <= '0;
              in_radius <= 1'b0;
              m <= (cfg_params == 7'd0) ? MW'(1) :
                   (int'(cfg_params) > MAX_PARAMS) ? MW'(MAX_PARAMS) : MW'(cfg_params);
              if (count == '0) begin
                status <= STS_EMPTY;
                state  <= ST_EMIT1;
              end else begin
                state <= ST_Q_RR;
              end
            end
          endcase
        end

        ST_EMIT1: begin
          if (out_free) state <= ST_IDLE;
        end

        ST_Q_RR: begin
          rr    <= prod[31:0];
          pt    <= '0;
          state <= ST_D_RD;
        end

        ST_D_RD: begin
          d2acc <= '0;
          ax    <= 2'd0;
          state <= ST_D_SQ;
        end

        ST_D_SQ: state <= ST_D_ACC;

        ST_D_ACC: begin
          d2acc <= d2_new;
          if (ax == 2'd2) begin
            state <= ST_D_END;
          end else begin
            ax    <= ax + 2'd1;
            state <= ST_D_SQ;
          end
        end

        ST_D_END: begin
          d2[pt] <= d2acc;
          if (d2acc < {2'b00, rr}) in_radius <= 1'b1;
          if (pt == '0 || d2acc < best_d2) begin
            best    <= pt;
            best_d2 <= d2acc;
          end
          if (pt_last) begin
            pt    <= '0;
            state <= (in_radius || d2acc < {2'b00, rr}) ? ST_F_SAT : ST_F_RD;
          end else begin
            pt    <= pt + PAW'(1);
            state <= ST_D_RD;
          end
        end

        ST_F_RD: begin
          ax <= 2'd0;
          if (d2[pt] != '0) begin
            state <= ST_F_MUL;
          end else if (pt_last) begin
            state <= ST_F_SAT;
          end else begin
            pt <= pt + PAW'(1);
          end
        end

        ST_F_MUL: state <= ST_F_DIV;
        ST_F_DIV: state <= ST_F_WAIT;

        ST_F_WAIT: begin
          if (div_done) begin
            facc[ax] <= neg ? (facc[ax] - term) : (facc[ax] + term);
            if (ax != 2'd2) begin
              ax    <= ax + 2'd1;
              state <= ST_F_MUL;
            end else if (pt_last) begin
              state <= ST_F_SAT;
            end else begin
              pt    <= pt + PAW'(1);
              state <= ST_F_RD;
            end
          end
        end

        ST_F_SAT: begin
          fx    <= sat24(facc[0]);
          fy    <= sat24(facc[1]);
          fz    <= sat24(facc[2]);
          state <= ST_SEL;
        end

        ST_SEL: begin
          j   <= '0;
          pt  <= '0;
          sum <= '0;
          sh  <= '0;
          den <= '0;
          state <= near ? ST_N_RD : ST_W_DIV;
        end

        ST_N_RD: state <= ST_N_EMIT;

        ST_N_EMIT: begin
          if (out_free) begin
            if (j_last) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + JW'(1);
              state <= ST_N_RD;
            end
          end
        end

        ST_W_DIV: state <= ST_W_WAIT;

        ST_W_WAIT: begin
          if (div_done) begin
            wt[pt] <= div_quo[52:0];
            sum    <= sum + SUMW'(div_quo[52:0]);
            if (pt_last) begin
              state <= ST_SHIFT;
            end else begin
              pt    <= pt + PAW'(1);
              state <= ST_W_DIV;
            end
          end
        end

        ST_SHIFT: begin
          if (sum[SUMW-1:32] != '0) begin
            sum <= sum >> 1;
            sh  <= sh + 6'd1;
          end else begin
            pt    <= '0;
            state <= ST_DEN;
          end
        end

        ST_DEN: begin
          wt[pt] <= wsh;
          den    <= den + wsh[31:0];
          if (pt_last) begin
            pt    <= '0;
            acc   <= '0;
            state <= ST_O_RD;
          end else begin
            pt <= pt + PAW'(1);
          end
        end

        ST_O_RD:  state <= ST_O_MUL;
        ST_O_MUL: state <= ST_O_ACC;

        ST_O_ACC: begin
          acc <= acc + ACCW'(prod);
          if (pt_last) begin
            state <= ST_O_DIV;
          end else begin
            pt    <= pt + PAW'(1);
            state <= ST_O_RD;
          end
        end

        ST_O_DIV: state <= ST_O_WAIT;

        ST_O_WAIT: begin
          if (div_done) begin
            res   <= (div_quo > NUMW'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
            state <= ST_O_EMIT;
          end
        end

        ST_O_EMIT: begin
          if (out_free) begin
            if (j_last) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + JW'(1);
              pt    <= '0;
              acc   <= '0;
              state <= ST_O_RD;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/idpi_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Stand-alone; shared by the interpolator sequencer.
`default_nettype none

module idpi_div #(
  parameter int NUMW = 53,
  parameter int DENW = 34
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [NUMW-1:0] num,
  input  wire logic [DENW-1:0] den,
  output logic                 done,
  output logic [NUMW-1:0]      quo
);

  localparam int CNTW = $clog2(NUMW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [DENW-1:0] rem;
  logic [DENW-1:0] dv;
  logic [NUMW-1:0] q;
  logic [DENW:0]   trial;
  logic [DENW:0]   diff;
  logic            ge;

  assign trial = {rem, q[NUMW-1]};
  assign ge    = (trial >= {1'b0, dv});
  assign diff  = trial - {1'b0, dv};
  assign quo   = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= num;
        dv   <= den;
      end else if (busy) begin
        rem <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
        q   <= {q[NUMW-2:0], ge};
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(NUMW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/idpi_interp_checker.sv @@
// Checker for the inverse-distance parameter interpolator: predicts result words
// from the accepted request and register words and compares each whole word, with the
// value left out where it is not known. Depends on idpi_pkg.
`timescale 1ns / 100ps

module idpi_interp_checker
  import idpi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_word_t   req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_word_t   rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  rsp_word_t   expected_words[$];
  bit          expected_known[$];
  logic [6:0]  params_reg;
  logic [31:0] thresh_reg;
  logic [15:0] radius_reg;
  int unsigned stored_count;
  logic [15:0] stored_pos[MAX_POINTS_DEF][3];
  logic [15:0] stored_val[MAX_POINTS_DEF * MAX_PARAMS_DEF];
  bit          stored_set[MAX_POINTS_DEF * MAX_PARAMS_DEF];

  // value is only compared when every slot it depends on has been written
  task automatic push_word(logic [1:0] sts, logic [5:0] idx, logic [15:0] val,
                           longint fx, longint fy, longint fz, logic lst, bit known);
    rsp_word_t w;
    w.status = sts;
    w.out_param_index = idx;
    w.out_value = val;
    w.force_x = fx[23:0];
    w.force_y = fy[23:0];
    w.force_z = fz[23:0];
    w.last = lst;
    expected_words = {expected_words, w};
    expected_known = {expected_known, known};
  endtask

  task automatic predict_query(req_word_t q);
    longint unsigned d2[MAX_POINTS_DEF];
    longint unsigned wt[MAX_POINTS_DEF];
    longint frc[3];
    longint df;
    longint unsigned rr, mag, t, sum, den, acc, v;
    logic [15:0] qp[3];
    int best, m, sh;
    bit in_radius;
    bit known;
    frc = '{0, 0, 0};
    qp[0] = q.pos_x;
    qp[1] = q.pos_y;
    qp[2] = q.pos_z;
    if (stored_count == 0) begin
      push_word(STS_EMPTY, 0, 0, 0, 0, 0, 1'b1, 1'b1);
      return;
    end
    rr = longint'(radius_reg) * longint'(radius_reg);
    in_radius = 0;
    best = 0;
    for (int i = 0; i < stored_count; i++) begin
      d2[i] = 0;
      for (int a = 0; a < 3; a++) begin
        df = longint'(stored_pos[i][a]) - longint'(qp[a]);
        d2[i] += longint'(df * df);
      end
      if (d2[i] < rr) in_radius = 1;
      if (d2[i] < d2[best]) best = i;
    end
    if (!in_radius) begin
      for (int i = 0; i < stored_count; i++) begin
        if (d2[i] == 0) continue;
        for (int a = 0; a < 3; a++) begin
          df = longint'(stored_pos[i][a]) - longint'(qp[a]);
          mag = df < 0 ? -df : df;
          t = (mag * radius_reg * 65536) / d2[i];
          frc[a] += df < 0 ? -longint'(t) : longint'(t);
        end
      end
      for (int a = 0; a < 3; a++) begin
        if (frc[a] > 8388607) frc[a] = 8388607;
        if (frc[a] < -8388608) frc[a] = -8388608;
      end
    end
    m = params_reg;
    if (m < 1) m = 1;
    if (m > MAX_PARAMS_DEF) m = MAX_PARAMS_DEF;
    if (d2[best] < thresh_reg || d2[best] == 0) begin
      for (int j = 0; j < m; j++)
        push_word(STS_OK, 6'(j), stored_val[best * MAX_PARAMS_DEF + j],
                  frc[0], frc[1], frc[2], j == m - 1,
                  stored_set[best * MAX_PARAMS_DEF + j]);
      return;
    end
    sum = 0;
    for (int i = 0; i < stored_count; i++) begin
      wt[i] = (64'd1 << 52) / d2[i];
      sum += wt[i];
    end
    sh = 0;
    while (sh < 63 && ((sum >> sh) >> 32) != 0) sh++;
    den = 0;
    for (int i = 0; i < stored_count; i++) begin
      wt[i] = wt[i] >> sh;
      den += wt[i];
    end
    for (int j = 0; j < m; j++) begin
      acc = 0;
      known = 1;
      for (int i = 0; i < stored_count; i++) begin
        acc += longint'(stored_val[i * MAX_PARAMS_DEF + j]) * wt[i];
        if (!stored_set[i * MAX_PARAMS_DEF + j]) known = 0;
      end
      v = den != 0 ? acc / den : 0;
      if (v > 16'hFFFF) v = 16'hFFFF;
      push_word(STS_OK, 6'(j), v[15:0], frc[0], frc[1], frc[2], j == m - 1, known);
    end
  endtask

  task automatic predict_request(req_word_t w);
    logic [1:0] sts;
    sts = STS_OK;
    case (w.req_type)
      REQ_QUERY: begin
        predict_query(w);
        return;
      end
      REQ_CLEAR: stored_count = 0;
      REQ_APPEND: begin
        if (stored_count >= MAX_POINTS_DEF) begin
          sts = STS_FULL;
        end else begin
          stored_pos[stored_count][0] = w.pos_x;
          stored_pos[stored_count][1] = w.pos_y;
          stored_pos[stored_count][2] = w.pos_z;
          stored_count++;
        end
      end
      default: begin
        if (w.point_index >= stored_count || w.param_index >= MAX_PARAMS_DEF) begin
          sts = STS_RANGE;
        end else begin
          stored_val[w.point_index * MAX_PARAMS_DEF + w.param_index] = w.param_value;
          stored_set[w.point_index * MAX_PARAMS_DEF + w.param_index] = 1'b1;
        end
      end
    endcase
    push_word(sts, 0, 0, 0, 0, 0, 1'b1, 1'b1);
  endtask

  always @(posedge clk) begin
    rsp_word_t exp_w;
    rsp_word_t cmp_w;
    bit        known;
    if (rst) begin
      errors = 0;
      params_reg = PARAMS_RST;
      thresh_reg = THRESH_RST;
      radius_reg = RADIUS_RST;
      stored_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PARAMS: params_reg = cfg_data[6:0];
          CFG_THRESH: thresh_reg = cfg_data;
          CFG_RADIUS: radius_reg = cfg_data[15:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) predict_request(req);
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, rsp);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          known = expected_known.pop_front();
          cmp_w = rsp;
          if (!known) cmp_w.out_value = exp_w.out_value;
          if (cmp_w !== exp_w) begin
            $display("%0t: word mismatch, expected %p, actual %p", $time, exp_w, rsp);
            errors++;
          end
        end
      end
    end
    pending <= expected_words.size();
  end

endmodule

@@ dv/inverse_distance_param_interpolator_unit_tb.sv @@
// Testbench top for the inverse-distance parameter interpolator: clock, reset,
// request and register stimulus, result stalls and the verdict.
// Depends on idpi_pkg, idpi_interp_checker and the unit under test.
`timescale 1ns / 100ps

module inverse_distance_param_interpolator_unit_tb;
  import idpi_pkg::*;

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  req_word_t   req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  rsp_word_t   rsp;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          errors, pending;
  int          burst_left = 0;
  int unsigned cycle_count = 0;
  int unsigned tb_count = 0;
  logic [15:0] tb_pos[16][3];

  always #5 clk = ~clk;

  inverse_distance_param_interpolator_unit dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  idpi_interp_checker checker_i (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  // receiver stall pattern is chosen by bits 9:8 of cycle_count: none, random, mostly stalled, rare
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[9:8])
      2'd0: rsp_stall <= 1'b0;
      2'd1: rsp_stall <= 1'($urandom_range(0, 1));
      2'd2: rsp_stall <= cycle_count[2:0] != 0;
      default: rsp_stall <= $urandom_range(0, 9) == 0;
    endcase
  end

  function automatic req_word_t make_word(logic [1:0] t, logic [3:0] pi, logic [5:0] ki,
                                          logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                          logic [15:0] v);
    make_word = '{t, pi, ki, x, y, z, v};
  endfunction

  task automatic send_request(req_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    case (w.req_type)
      REQ_CLEAR: tb_count = 0;
      REQ_APPEND: if (tb_count < 16) begin
        tb_pos[tb_count] = '{w.pos_x, w.pos_y, w.pos_z};
        tb_count++;
      end
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    int r, p;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      send_request(make_word(REQ_CLEAR, 4'($urandom), 6'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)));
    end else if (r < 30) begin
      send_request(make_word(REQ_APPEND, 4'($urandom), 6'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)));
    end else if (r < 60) begin
      p = (tb_count > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, tb_count - 1)
                                                      : $urandom_range(0, 15);
      send_request(make_word(REQ_WRITE, 4'(p), 6'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)));
    end else if (tb_count > 0 && $urandom_range(0, 3) == 0) begin
      p = $urandom_range(0, tb_count - 1);
      send_request(make_word(REQ_QUERY, 4'($urandom), 6'($urandom), tb_pos[p][0],
                             tb_pos[p][1] ^ 16'($urandom_range(0, 3)), tb_pos[p][2],
                             16'($urandom)));
    end else begin
      send_request(make_word(REQ_QUERY, 4'($urandom), 6'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom)));
    end
  endtask

  initial begin
    logic [31:0] par_set[6];
    logic [31:0] thr_set[6];
    logic [31:0] rad_set[6];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // store the first two parameters of every slot
    for (int p = 0; p < 16; p++)
      send_request(make_word(REQ_APPEND, 0, 0, 16'($urandom), 16'($urandom),
                             16'($urandom), 0));
    send_request(make_word(REQ_APPEND, 0, 0, 1, 2, 3, 0));
    for (int p = 0; p < 16; p++)
      for (int k = 0; k < 2; k++)
        send_request(make_word(REQ_WRITE, 4'(p), 6'(k), 0, 0, 0, 16'($urandom)));
    send_request(make_word(REQ_CLEAR, 0, 0, 0, 0, 0, 0));

    // directed
    send_request(make_word(REQ_QUERY, 0, 0, 16'h1234, 0, 16'hFFFF, 0));
    send_request(make_word(REQ_WRITE, 0, 0, 0, 0, 0, 16'hFFFF));
    send_request(make_word(REQ_APPEND, 0, 0, 0, 0, 0, 0));
    send_request(make_word(REQ_APPEND, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
    send_request(make_word(REQ_APPEND, 0, 0, 16'hFFFF, 0, 16'hFFFF, 0));
    send_request(make_word(REQ_WRITE, 0, 0, 0, 0, 0, 16'hFFFF));
    send_request(make_word(REQ_WRITE, 1, 63, 0, 0, 0, 16'h0000));
    send_request(make_word(REQ_WRITE, 3, 5, 0, 0, 0, 16'hAAAA));
    send_request(make_word(REQ_WRITE, 15, 63, 0, 0, 0, 16'h5555));
    wait_drained();
    write_register(CFG_PARAMS, 4);
    write_register(CFG_RADIUS, 0);
    write_register(CFG_THRESH, 0);
    send_request(make_word(REQ_QUERY, 0, 0, 0, 0, 0, 0));
    send_request(make_word(REQ_QUERY, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0));
    send_request(make_word(REQ_QUERY, 0, 0, 16'hFFFF, 16'h8000, 16'hFFFF, 0));
    send_request(make_word(REQ_QUERY, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0));
    send_request(make_word(REQ_QUERY, 0, 0, 16'h0100, 16'h0100, 0, 0));
    wait_drained();
    write_register(CFG_RADIUS, 32'h2000);
    write_register(CFG_THRESH, 32'hFFFF_FFFF);
    send_request(make_word(REQ_QUERY, 0, 0, 16'h4000, 16'h4000, 16'h4000, 0));
    send_request(make_word(REQ_QUERY, 0, 0, 16'h0800, 16'h0, 16'h0, 0));

    par_set = '{32'(PARAMS_RST), 1, 0, 127, 3, 6};
    thr_set = '{THRESH_RST, 0, 32'hFFFF_FFFF, 32'h0010_0000, 0, 32'h0100_0000};
    rad_set = '{32'(RADIUS_RST), 32'hFFFF, 0, 32'h0100, 32'h0040, 32'h1000};
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      write_register(CFG_PARAMS, par_set[ph]);
      write_register(CFG_THRESH, thr_set[ph]);
      write_register(CFG_RADIUS, rad_set[ph]);
      repeat (6) send_random();
    end
    wait_drained();
    write_register(CFG_PARAMS, 32'(PARAMS_RST));
    write_register(CFG_THRESH, THRESH_RST);
    write_register(CFG_RADIUS, 32'(RADIUS_RST));
    wait_drained();

    if (errors == 0)
      $display("inverse_distance_param_interpolator_unit_tb: PASS");
    else
      $display("inverse_distance_param_interpolator_unit_tb: FAIL");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("inverse_distance_param_interpolator_unit_tb: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/idpi_pkg.sv
rtl/core/idpi_div.sv
rtl/core/inverse_distance_param_interpolator_unit.sv
dv/idpi_interp_checker.sv
dv/inverse_distance_param_interpolator_unit_tb.sv
